// ===== sv/ffa_pkg.sv =====
// Shared constants, handshake codes and controller/datapath bundles for the
// first-fit free-list allocator. No dependencies.
`default_nettype none
package ffa_pkg;

    localparam int ARENA_UNITS      = 4096;
    localparam int UNIT_BYTES       = 8;
    localparam int UNIT_SHIFT       = $clog2(UNIT_BYTES);
    localparam int AW               = $clog2(ARENA_UNITS);
    localparam int MIN_EXPAND_RESET = 511;
    localparam int WALK_LIMIT       = 2 * ARENA_UNITS + 4;
    localparam int SW               = $clog2(WALK_LIMIT + 1);

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [4:0] OP_NOP     = 5'd0;
    localparam logic [4:0] OP_LOAD    = 5'd1;
    localparam logic [4:0] OP_SETUP   = 5'd2;
    localparam logic [4:0] OP_A_START = 5'd3;
    localparam logic [4:0] OP_A_LINK  = 5'd4;
    localparam logic [4:0] OP_A_RD    = 5'd5;
    localparam logic [4:0] OP_A_EV    = 5'd6;
    localparam logic [4:0] OP_A_SPLIT = 5'd7;
    localparam logic [4:0] OP_G_CHK   = 5'd8;
    localparam logic [4:0] OP_I_START = 5'd9;
    localparam logic [4:0] OP_I_EV    = 5'd10;
    localparam logic [4:0] OP_I_R1    = 5'd11;
    localparam logic [4:0] OP_I_R2    = 5'd12;
    localparam logic [4:0] OP_I_W1    = 5'd13;
    localparam logic [4:0] OP_I_W2    = 5'd14;
    localparam logic [4:0] OP_A_GRD   = 5'd15;
    localparam logic [4:0] OP_PUSH    = 5'd16;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] st;
    } cmd_t;

    typedef struct packed {
        logic req_free;
        logic zero_bytes;
        logic free_bad;
        logic fit;
        logic exact;
        logic p_eq_rover;
        logic steps_over;
        logic grow_fail;
        logic ins_cont;
        logic isteps_over;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== sv/ffa_req_if.sv =====
// Request channel: valid/ready handshake carrying one allocate or free word.
// No dependencies.
`default_nettype none
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [14:0] size_bytes;
    logic [11:0] block_addr;

    modport source (output valid, output req_type, output size_bytes, output block_addr,
                    input ready);
    modport sink (input valid, input req_type, input size_bytes, input block_addr,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/ffa_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result word.
// No dependencies.
`default_nettype none
interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] result_addr;
    logic [1:0]  status;

    modport source (output valid, output result_addr, output status, input ready);
    modport sink (input valid, input result_addr, input status, output ready);
endinterface
`default_nettype wire

// ===== sv/ffa_datapath.sv =====
// Allocator datapath: link/size memories, list pointers, walk counters and the
// output register. Executes one command from ffa_ctrl per cycle. Uses ffa_pkg.
`default_nettype none
module ffa_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ffa_pkg::cmd_t       cmd,
    output ffa_pkg::sts_t            sts,
    input  wire logic                in_type,
    input  wire logic [14:0]         in_bytes,
    input  wire logic [11:0]         in_baddr,
    input  wire logic [11:0]         min_expand,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [11:0]              out_addr,
    output logic [1:0]               out_status
);
    localparam int AW = ffa_pkg::AW;
    localparam int SW = ffa_pkg::SW;

    logic [AW-1:0] link_mem [ffa_pkg::ARENA_UNITS];
    logic [AW-1:0] size_mem [ffa_pkg::ARENA_UNITS];
    logic [AW-1:0] link_rd, size_rd;
    logic          link_we, size_we;
    logic [AW-1:0] link_waddr, size_waddr, link_wdata, size_wdata;
    logic [AW-1:0] link_raddr, size_raddr;

    logic          started_reg, started_next;
    logic [AW-1:0] rover_reg, rover_next;
    logic [AW:0]   brk_reg, brk_next;
    logic          ovalid_reg, ovalid_next;
    logic [11:0]   oaddr_reg, oaddr_next;
    logic [1:0]    ostat_reg, ostat_next;

    logic          type_reg, type_next;
    logic [14:0]   bytes_reg, bytes_next;
    logic [11:0]   baddr_reg, baddr_next;
    logic [AW-1:0] hdr_reg, hdr_next, p_reg, p_next, prev_reg, prev_next;
    logic [AW-1:0] nx_reg, nx_next, lnx_reg, lnx_next, up_reg, up_next;
    logic [AW-1:0] szh_reg, szh_next, sznx_reg, sznx_next, szp_reg, szp_next;
    logic [AW-1:0] nszh_reg, nszh_next, res_reg, res_next;
    logic [SW-1:0] steps_reg, steps_next, isteps_reg, isteps_next;

    logic [15:0]   bsum;
    logic [AW:0]   need, nu;
    logic [AW-1:0] me;
    logic [AW+1:0] brk_end;
    logic          c_keep, c_stop;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rd <= size_mem[size_raddr];
    end

    assign bsum    = {1'b0, bytes_reg} + 16'(ffa_pkg::UNIT_BYTES - 1);
    assign need    = (AW+1)'(bsum >> ffa_pkg::UNIT_SHIFT) + (AW+1)'(1);
    assign me      = (min_expand == '0) ? AW'(1) : min_expand;
    assign nu      = (need > {1'b0, me}) ? need : {1'b0, me};
    assign brk_end = {1'b0, brk_reg} + {1'b0, nu};
    assign c_keep  = (p_reg > hdr_reg) || (link_rd < hdr_reg);
    assign c_stop  = (p_reg >= link_rd) && ((hdr_reg > p_reg) || (hdr_reg < link_rd));

    always_comb
    begin
        sts.req_free    = type_reg;
        sts.zero_bytes  = (bytes_reg == '0);
        sts.free_bad    = (baddr_reg == '0) || (baddr_reg == 12'd1)
                          || ({1'b0, baddr_reg - 12'd1} >= brk_reg);
        sts.fit         = ({1'b0, size_rd} >= need);
        sts.exact       = ({1'b0, size_rd} == need);
        sts.p_eq_rover  = (p_reg == rover_reg);
        sts.steps_over  = (steps_reg >= SW'(ffa_pkg::WALK_LIMIT));
        sts.grow_fail   = (brk_end > (AW+2)'(ffa_pkg::ARENA_UNITS));
        sts.ins_cont    = c_keep && !c_stop;
        sts.isteps_over = (isteps_reg >= SW'(ffa_pkg::WALK_LIMIT));
        sts.out_free    = !ovalid_reg || out_ready;
    end

    always_comb
    begin
        started_next = started_reg;
        rover_next   = rover_reg;
        brk_next     = brk_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        oaddr_next   = oaddr_reg;
        ostat_next   = ostat_reg;
        type_next    = type_reg;
        bytes_next   = bytes_reg;
        baddr_next   = baddr_reg;
        hdr_next     = hdr_reg;
        p_next       = p_reg;
        prev_next    = prev_reg;
        nx_next      = nx_reg;
        lnx_next     = lnx_reg;
        up_next      = up_reg;
        szh_next     = szh_reg;
        sznx_next    = sznx_reg;
        szp_next     = szp_reg;
        nszh_next    = nszh_reg;
        res_next     = res_reg;
        steps_next   = steps_reg;
        isteps_next  = isteps_reg;
        link_we      = 1'b0;
        size_we      = 1'b0;
        link_waddr   = '0;
        size_waddr   = '0;
        link_wdata   = '0;
        size_wdata   = '0;
        link_raddr   = '0;
        size_raddr   = '0;
        unique case (cmd.op)
            ffa_pkg::OP_LOAD:
            begin
                type_next  = in_type;
                bytes_next = in_bytes;
                baddr_next = in_baddr;
            end
            ffa_pkg::OP_SETUP:
            begin
                if (!started_reg)
                begin
                    link_we      = 1'b1;
                    size_we      = 1'b1;
                    rover_next   = '0;
                    started_next = 1'b1;
                end
                hdr_next = baddr_reg - 12'd1;
            end
            ffa_pkg::OP_A_START:
            begin
                prev_next  = rover_reg;
                link_raddr = rover_reg;
                steps_next = '0;
            end
            ffa_pkg::OP_A_LINK:
            begin
                p_next = link_rd;
            end
            ffa_pkg::OP_A_RD:
            begin
                link_raddr = p_reg;
                size_raddr = p_reg;
            end
            ffa_pkg::OP_A_EV:
            begin
                if (sts.fit)
                begin
                    rover_next = prev_reg;
                    if (sts.exact)
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = link_rd;
                        res_next   = p_reg + AW'(1);
                    end
                    else
                    begin
                        size_we    = 1'b1;
                        size_waddr = p_reg;
                        size_wdata = size_rd - need[AW-1:0];
                        p_next     = p_reg + (size_rd - need[AW-1:0]);
                    end
                end
                else if (!sts.p_eq_rover)
                begin
                    steps_next = steps_reg + SW'(1);
                    prev_next  = p_reg;
                    p_next     = link_rd;
                end
            end
            ffa_pkg::OP_A_SPLIT:
            begin
                size_we    = 1'b1;
                size_waddr = p_reg;
                size_wdata = need[AW-1:0];
                res_next   = p_reg + AW'(1);
            end
            ffa_pkg::OP_G_CHK:
            begin
                if (!sts.grow_fail)
                begin
                    size_we    = 1'b1;
                    size_waddr = brk_reg[AW-1:0];
                    size_wdata = nu[AW-1:0];
                    hdr_next   = brk_reg[AW-1:0];
                    brk_next   = brk_end[AW:0];
                end
            end
            ffa_pkg::OP_I_START:
            begin
                p_next      = rover_reg;
                isteps_next = '0;
                link_raddr  = rover_reg;
            end
            ffa_pkg::OP_I_EV:
            begin
                link_raddr = link_rd;
                if (sts.ins_cont)
                begin
                    p_next      = link_rd;
                    isteps_next = isteps_reg + SW'(1);
                end
                else
                begin
                    nx_next    = link_rd;
                    size_raddr = hdr_reg;
                end
            end
            ffa_pkg::OP_I_R1:
            begin
                szh_next   = size_rd;
                lnx_next   = link_rd;
                size_raddr = nx_reg;
            end
            ffa_pkg::OP_I_R2:
            begin
                sznx_next  = size_rd;
                size_raddr = p_reg;
            end
            ffa_pkg::OP_I_W1:
            begin
                szp_next   = size_rd;
                link_we    = 1'b1;
                link_waddr = hdr_reg;
                if (({1'b0, hdr_reg} + {1'b0, szh_reg}) == {1'b0, nx_reg})
                begin
                    size_we    = 1'b1;
                    size_waddr = hdr_reg;
                    size_wdata = szh_reg + sznx_reg;
                    link_wdata = lnx_reg;
                    up_next    = lnx_reg;
                    nszh_next  = szh_reg + sznx_reg;
                end
                else
                begin
                    link_wdata = nx_reg;
                    up_next    = nx_reg;
                    nszh_next  = szh_reg;
                end
            end
            ffa_pkg::OP_I_W2:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                rover_next = p_reg;
                if (({1'b0, p_reg} + {1'b0, szp_reg}) == {1'b0, hdr_reg})
                begin
                    size_we    = 1'b1;
                    size_waddr = p_reg;
                    size_wdata = szp_reg + nszh_reg;
                    link_wdata = up_reg;
                end
                else
                begin
                    link_wdata = hdr_reg;
                end
            end
            ffa_pkg::OP_A_GRD:
            begin
                link_raddr = rover_reg;
                if (!sts.steps_over)
                begin
                    steps_next = steps_reg + SW'(1);
                    prev_next  = rover_reg;
                end
            end
            ffa_pkg::OP_PUSH:
            begin
                ovalid_next = 1'b1;
                ostat_next  = cmd.st;
                oaddr_next  = (cmd.st == ffa_pkg::ST_DONE && type_reg == ffa_pkg::REQ_ALLOC)
                              ? res_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            rover_reg   <= '0;
            brk_reg     <= (AW+1)'(1);
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
            rover_reg   <= rover_next;
            brk_reg     <= brk_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oaddr_reg  <= oaddr_next;
        ostat_reg  <= ostat_next;
        type_reg   <= type_next;
        bytes_reg  <= bytes_next;
        baddr_reg  <= baddr_next;
        hdr_reg    <= hdr_next;
        p_reg      <= p_next;
        prev_reg   <= prev_next;
        nx_reg     <= nx_next;
        lnx_reg    <= lnx_next;
        up_reg     <= up_next;
        szh_reg    <= szh_next;
        sznx_reg   <= sznx_next;
        szp_reg    <= szp_next;
        nszh_reg   <= nszh_next;
        res_reg    <= res_next;
        steps_reg  <= steps_next;
        isteps_reg <= isteps_next;
    end

    assign out_valid  = ovalid_reg;
    assign out_addr   = oaddr_reg;
    assign out_status = ostat_reg;

endmodule
`default_nettype wire

// ===== sv/ffa_ctrl.sv =====
// Allocator sequencer: walks the allocate, grow and insert steps and issues
// one datapath command per cycle. Uses ffa_pkg.
`default_nettype none
module ffa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ffa_pkg::sts_t sts,
    output ffa_pkg::cmd_t      cmd
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SETUP   = 4'd1;
    localparam logic [3:0] S_A_START = 4'd2;
    localparam logic [3:0] S_A_LINK  = 4'd3;
    localparam logic [3:0] S_A_RD    = 4'd4;
    localparam logic [3:0] S_A_EV    = 4'd5;
    localparam logic [3:0] S_A_SPLIT = 4'd6;
    localparam logic [3:0] S_G_CHK   = 4'd7;
    localparam logic [3:0] S_I_START = 4'd8;
    localparam logic [3:0] S_I_EV    = 4'd9;
    localparam logic [3:0] S_I_R1    = 4'd10;
    localparam logic [3:0] S_I_R2    = 4'd11;
    localparam logic [3:0] S_I_W1    = 4'd12;
    localparam logic [3:0] S_I_W2    = 4'd13;
    localparam logic [3:0] S_A_GRD   = 4'd14;
    localparam logic [3:0] S_PUSH    = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        in_ready   = 1'b0;
        cmd.op     = ffa_pkg::OP_NOP;
        cmd.st     = st_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = ffa_pkg::OP_LOAD;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.op = ffa_pkg::OP_SETUP;
                if (sts.req_free)
                begin
                    if (sts.free_bad)
                    begin
                        st_next    = ffa_pkg::ST_IGNORED;
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_I_START;
                    end
                end
                else if (sts.zero_bytes)
                begin
                    st_next    = ffa_pkg::ST_IGNORED;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_A_START;
                end
            end
            S_A_START:
            begin
                cmd.op     = ffa_pkg::OP_A_START;
                state_next = S_A_LINK;
            end
            S_A_LINK:
            begin
                cmd.op     = ffa_pkg::OP_A_LINK;
                state_next = S_A_RD;
            end
            S_A_RD:
            begin
                cmd.op     = ffa_pkg::OP_A_RD;
                state_next = S_A_EV;
            end
            S_A_EV:
            begin
                cmd.op = ffa_pkg::OP_A_EV;
                priority if (sts.fit && sts.exact)
                begin
                    st_next    = ffa_pkg::ST_DONE;
                    state_next = S_PUSH;
                end
                else if (sts.fit)
                begin
                    state_next = S_A_SPLIT;
                end
                else if (sts.p_eq_rover)
                begin
                    state_next = S_G_CHK;
                end
                else if (sts.steps_over)
                begin
                    st_next    = ffa_pkg::ST_OOM;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_A_SPLIT:
            begin
                cmd.op     = ffa_pkg::OP_A_SPLIT;
                st_next    = ffa_pkg::ST_DONE;
                state_next = S_PUSH;
            end
            S_G_CHK:
            begin
                cmd.op = ffa_pkg::OP_G_CHK;
                if (sts.grow_fail)
                begin
                    st_next    = ffa_pkg::ST_OOM;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_I_START;
                end
            end
            S_I_START:
            begin
                cmd.op     = ffa_pkg::OP_I_START;
                state_next = S_I_EV;
            end
            S_I_EV:
            begin
                cmd.op = ffa_pkg::OP_I_EV;
                if (!sts.ins_cont)
                begin
                    state_next = S_I_R1;
                end
                else if (sts.isteps_over)
                begin
                    st_next    = sts.req_free ? ffa_pkg::ST_IGNORED : ffa_pkg::ST_OOM;
                    state_next = S_PUSH;
                end
            end
            S_I_R1:
            begin
                cmd.op     = ffa_pkg::OP_I_R1;
                state_next = S_I_R2;
            end
            S_I_R2:
            begin
                cmd.op     = ffa_pkg::OP_I_R2;
                state_next = S_I_W1;
            end
            S_I_W1:
            begin
                cmd.op     = ffa_pkg::OP_I_W1;
                state_next = S_I_W2;
            end
            S_I_W2:
            begin
                cmd.op = ffa_pkg::OP_I_W2;
                if (sts.req_free)
                begin
                    st_next    = ffa_pkg::ST_DONE;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_A_GRD;
                end
            end
            S_A_GRD:
            begin
                cmd.op = ffa_pkg::OP_A_GRD;
                if (sts.steps_over)
                begin
                    st_next    = ffa_pkg::ST_OOM;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_A_LINK;
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = ffa_pkg::OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ffa_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/first_fit_free_list_allocator_top.sv =====
// First-fit free-list heap allocator, top level: APB register, controller and
// datapath. Depends on ffa_pkg, ffa_req_if, ffa_rsp_if, ffa_ctrl, ffa_datapath.
//
// Usage: each request word on req is an allocate (req_type 0, size_bytes) or
// a free (req_type 1, block_addr). Exactly one response word comes back on
// rsp per request, in order: result_addr and status (0 done, 1 out of
// memory, 2 ignored). One request is in flight at a time; req.ready is high
// only while the sequencer is idle.
// An allocate tries each block on the walk in turn and splits one that is
// larger than needed; if none fits, the heap grows (or the request ends out
// of memory) and the new block is inserted before the walk goes on. A free
// walks the list to insert the block. The steps are paced by the single read
// port of the link and size memories.
// The response sits in an output register; if rsp stalls, a finished request
// waits there while the next request is already taken and worked on.
// Reset clears the pointers (rover 0, break 1) and the register to 511;
// the memories need no clearing, the sentinel is written by the first request.
// min_expand is at APB address 0; the user writes it only while the block is idle, the block does not enforce it.
`default_nettype none
module first_fit_free_list_allocator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ffa_req_if.sink          req,
    ffa_rsp_if.source        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [11:0]   min_expand_reg, min_expand_next;
    ffa_pkg::cmd_t cmd;
    ffa_pkg::sts_t sts;

    always_comb
    begin
        min_expand_next = min_expand_reg;
        if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            min_expand_next = pwdata[11:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_expand_reg <= 12'(ffa_pkg::MIN_EXPAND_RESET);
        end
        else
        begin
            min_expand_reg <= min_expand_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {20'd0, min_expand_reg} : 32'd0;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffa_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_type    (req.req_type),
        .in_bytes   (req.size_bytes),
        .in_baddr   (req.block_addr),
        .min_expand (min_expand_reg),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_addr   (rsp.result_addr),
        .out_status (rsp.status)
    );

endmodule
`default_nettype wire

// ===== sv/ffa_checker.sv =====
// Port-level checks for the allocator top and their bind.
// Depends on ffa_pkg and first_fit_free_list_allocator_top.
`default_nettype none
module ffa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [11:0] rsp_addr,
    input wire logic [1:0]  rsp_status
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr) && $stable(rsp_status))
        else $error("response changed while stalled");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status == ffa_pkg::ST_DONE || rsp_status == ffa_pkg::ST_OOM
                      || rsp_status == ffa_pkg::ST_IGNORED)
        else $error("illegal status code");

    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ffa_pkg::ST_DONE |-> rsp_addr == 12'd0)
        else $error("failed request returned an address");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind first_fit_free_list_allocator_top ffa_checker u_ffa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_addr   (rsp.result_addr),
    .rsp_status (rsp.status)
);
`default_nettype wire
